[src/lsep_pkg.sv]
// shared types, constants and color wheel function for the led strip pixel encoder
`timescale 1ns / 1ps

package lsep_pkg;

    localparam int STRIP_PIXELS_DEF = 64;
    localparam int BITS_PER_PIXEL   = 24;
    localparam int BIT_CNT_W        = $clog2(BITS_PER_PIXEL);

    localparam int PIXEL_W  = 6;
    localparam int STEP_W   = 11;
    localparam int PHASE_W  = 2;
    localparam int COLOR_W  = 24;
    localparam int CODE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // effect modes
    localparam logic [1:0] MODE_RAINBOW       = 2'd0;
    localparam logic [1:0] MODE_RAINBOW_CYCLE = 2'd1;
    localparam logic [1:0] MODE_CHASE         = 2'd2;
    localparam logic [1:0] MODE_CHASE_RAINBOW = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASE_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_CODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE   = 2'd3;

    localparam logic [7:0] WHEEL_SEG  = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [7:0] WHEEL_MAX  = 8'd255;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_index;
        logic [STEP_W-1:0]  frame_step;
        logic [PHASE_W-1:0] chase_phase;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]  pwm_code;
        logic [COLOR_W-1:0] pixel_color;
        logic               bit_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         effect_mode;
        logic [COLOR_W-1:0] chase_color;
    } t_color_cfg;

    // three-segment ramp, packed green, red, blue
    function automatic logic [COLOR_W-1:0] wheel(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] v;
        logic [9:0] v3;
        logic [7:0] up;
        logic [7:0] down;
        w = WHEEL_MAX - pos;
        if (w < WHEEL_SEG) begin
            v = w;
        end else if (w < WHEEL_SEG2) begin
            v = w - WHEEL_SEG;
        end else begin
            v = w - WHEEL_SEG2;
        end
        v3   = {2'b00, v} + {1'b0, v, 1'b0};
        up   = v3[7:0];
        down = WHEEL_MAX - up;
        if (w < WHEEL_SEG) begin
            wheel = {8'd0, down, up};
        end else if (w < WHEEL_SEG2) begin
            wheel = {up, 8'd0, down};
        end else begin
            wheel = {down, up, 8'd0};
        end
    endfunction

endpackage

[src/lsep_color.sv]
// pixel color selection for the four effect modes
`timescale 1ns / 1ps

module lsep_color #(
    parameter int STRIP_PIXELS = lsep_pkg::STRIP_PIXELS_DEF
) (
    input  lsep_pkg::t_in_item               i_item,
    input  lsep_pkg::t_color_cfg             i_cfg,
    output logic [lsep_pkg::COLOR_W-1:0]     o_color
);

    localparam int TAB_DEPTH = 2 ** lsep_pkg::PIXEL_W;

    logic [7:0] w_div_tab  [TAB_DEPTH];
    logic [1:0] w_mod3_tab [TAB_DEPTH];

    // constant tables: p*256/N and p%3
    for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_tab
        localparam logic [7:0] DIV_V  = 8'((i * 256) / STRIP_PIXELS);
        localparam logic [1:0] MOD3_V = 2'(i % 3);
        assign w_div_tab[i]  = DIV_V;
        assign w_mod3_tab[i] = MOD3_V;
    end

    logic [lsep_pkg::PIXEL_W-1:0] w_p;
    logic [lsep_pkg::STEP_W-1:0]  w_j;
    logic [lsep_pkg::PHASE_W-1:0] w_q;
    logic                         w_dark;
    logic                         w_lit;
    logic [7:0]                   w_pos_rb;
    logic [7:0]                   w_pos_cyc;
    logic [lsep_pkg::STEP_W:0]    w_sum;
    logic [8:0]                   w_fold;
    logic [7:0]                   w_pos_tr;
    logic [lsep_pkg::COLOR_W-1:0] w_sel;

    assign w_p = i_item.pixel_index;
    assign w_j = i_item.frame_step;
    assign w_q = i_item.chase_phase;

    assign w_dark = 32'(w_p) >= STRIP_PIXELS;
    assign w_lit  = (w_mod3_tab[w_p] == w_q);

    assign w_pos_rb  = {2'b00, w_p} + w_j[7:0];
    assign w_pos_cyc = w_div_tab[w_p] + w_j[7:0];

    // mod 255 by folding the high bits onto the low byte, then one correction
    // p - q + j reaches 2110 for a lit pixel, so the sum needs one bit above the step
    assign w_sum  = {6'd0, w_p} - {10'd0, w_q} + {1'b0, w_j};
    assign w_fold = {1'b0, w_sum[7:0]} + {5'd0, w_sum[lsep_pkg::STEP_W:8]};
    assign w_pos_tr = (w_fold >= {1'b0, lsep_pkg::WHEEL_MAX})
                    ? 8'(w_fold - {1'b0, lsep_pkg::WHEEL_MAX}) : w_fold[7:0];

    always_comb begin
        unique case (i_cfg.effect_mode)
            lsep_pkg::MODE_RAINBOW: begin
                w_sel = lsep_pkg::wheel(w_pos_rb);
            end
            lsep_pkg::MODE_RAINBOW_CYCLE: begin
                w_sel = lsep_pkg::wheel(w_pos_cyc);
            end
            lsep_pkg::MODE_CHASE: begin
                w_sel = w_lit ? i_cfg.chase_color : '0;
            end
            lsep_pkg::MODE_CHASE_RAINBOW: begin
                w_sel = w_lit ? lsep_pkg::wheel(w_pos_tr) : '0;
            end
        endcase
    end

    assign o_color = w_dark ? '0 : w_sel;

endmodule

[src/led_strip_effect_pixel_encoder_core.sv]
// top level: config registers, input register, color stage and bit code serializer
// an accepted item waits in the input register and moves into the serializer once it is free
// throughput: one code per cycle while the output is not stalled, 24 codes per item from the bit serializer
// the next item is held in the input register while the current pixel shifts out
// reset: synchronous active low, clears valids, counter and all config registers
`timescale 1ns / 1ps

module led_strip_effect_pixel_encoder_core #(
    parameter int STRIP_PIXELS = lsep_pkg::STRIP_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lsep_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lsep_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lsep_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsep_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [lsep_pkg::BIT_CNT_W-1:0] LAST_BIT =
        lsep_pkg::BIT_CNT_W'(lsep_pkg::BITS_PER_PIXEL - 1);

    logic [1:0]                   r_effect_mode;
    logic [lsep_pkg::COLOR_W-1:0] r_chase_color;
    logic [lsep_pkg::CODE_W-1:0]  r_one_code;
    logic [lsep_pkg::CODE_W-1:0]  r_zero_code;

    logic                         r_s1_valid;
    lsep_pkg::t_in_item           r_s1_item;

    logic                           r_ser_valid;
    logic [lsep_pkg::COLOR_W-1:0]   r_color;
    logic [lsep_pkg::COLOR_W-1:0]   r_shift;
    logic [lsep_pkg::BIT_CNT_W-1:0] r_cnt;

    lsep_pkg::t_color_cfg           w_cfg;
    logic [lsep_pkg::COLOR_W-1:0]   w_color;
    logic                           w_out_take;
    logic                           w_ser_done;
    logic                           w_ser_free;
    logic                           w_s1_move;
    logic                           w_in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode <= '0;
            r_chase_color <= '0;
            r_one_code    <= '0;
            r_zero_code   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lsep_pkg::CFG_EFFECT_MODE: r_effect_mode <= i_cfg_data[1:0];
                lsep_pkg::CFG_CHASE_COLOR: r_chase_color <= i_cfg_data;
                lsep_pkg::CFG_ONE_CODE:    r_one_code    <= i_cfg_data[lsep_pkg::CODE_W-1:0];
                lsep_pkg::CFG_ZERO_CODE:   r_zero_code   <= i_cfg_data[lsep_pkg::CODE_W-1:0];
            endcase
        end
    end

    assign w_out_take = r_ser_valid && !i_out_stall;
    assign w_ser_done = w_out_take && (r_cnt == LAST_BIT);
    assign w_ser_free = !r_ser_valid || w_ser_done;
    assign w_s1_move  = r_s1_valid && w_ser_free;
    assign o_in_stall = r_s1_valid && !w_ser_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_item <= i_in_item;
        end
    end

    assign w_cfg.effect_mode = r_effect_mode;
    assign w_cfg.chase_color = r_chase_color;

    lsep_color #(
        .STRIP_PIXELS (STRIP_PIXELS)
    ) u_color (
        .i_item  (r_s1_item),
        .i_cfg   (w_cfg),
        .o_color (w_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (w_s1_move) begin
            r_ser_valid <= 1'b1;
            r_cnt       <= '0;
        end else if (w_ser_done) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (w_out_take) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // msb of green goes first
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_color <= w_color;
            r_shift <= w_color;
        end else if (w_out_take) begin
            r_shift <= {r_shift[lsep_pkg::COLOR_W-2:0], 1'b0};
        end
    end

    assign o_out_valid            = r_ser_valid;
    assign o_out_item.pwm_code    = r_shift[lsep_pkg::COLOR_W-1] ? r_one_code : r_zero_code;
    assign o_out_item.pixel_color = r_color;
    assign o_out_item.bit_last    = (r_cnt == LAST_BIT);

endmodule

[src/lsep_checker.sv]
// port level checks for the pixel encoder, bound to the top level
`timescale 1ns / 1ps

module lsep_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_stall,
    input logic                o_out_valid,
    input lsep_pkg::t_out_item o_out_item
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output item changed while stalled");

    // color stays the same across the codes of one pixel
    a_color_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.bit_last)
        |=> (o_out_valid && $stable(o_out_item.pixel_color)))
        else $error("pixel color changed inside a pixel");

    // a new pixel never starts on its last code
    a_last_then_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.bit_last)
        |=> (!o_out_valid || !o_out_item.bit_last))
        else $error("last flag repeated after a finished pixel");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind led_strip_effect_pixel_encoder_core lsep_checker u_lsep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item)
);

[tb/sv/led_strip_effect_pixel_encoder_core_test.sv]
// self-checking testbench for the led strip pixel encoder: predicted bit codes vs dut output
`timescale 1ns / 1ps

module led_strip_effect_pixel_encoder_core_test;

    import lsep_pkg::*;

    // expected bit codes for every accepted pixel, with a private copy of the registers
    class pixel_scoreboard;
        logic [1:0]         mode;
        logic [COLOR_W-1:0] chase;
        logic [CODE_W-1:0]  one;
        logic [CODE_W-1:0]  zero;
        t_out_item          code_q[$];
        int                 mismatches;

        function new();
            mode       = MODE_RAINBOW;
            chase      = '0;
            one        = '0;
            zero       = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EFFECT_MODE: mode  = data[1:0];
                CFG_CHASE_COLOR: chase = data[COLOR_W-1:0];
                CFG_ONE_CODE:    one   = data[CODE_W-1:0];
                CFG_ZERO_CODE:   zero  = data[CODE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] ramp(int pos);
            int w;
            int r;
            int g;
            int b;
            w = 255 - (pos & 255);
            if (w < 85) begin
                r = 255 - 3 * w;
                g = 0;
                b = 3 * w;
            end else if (w < 170) begin
                w = w - 85;
                r = 0;
                g = 3 * w;
                b = 255 - 3 * w;
            end else begin
                w = w - 170;
                r = 3 * w;
                g = 255 - 3 * w;
                b = 0;
            end
            return {g[7:0], r[7:0], b[7:0]};
        endfunction

        function logic [COLOR_W-1:0] shade(t_in_item it);
            int p;
            int j;
            int q;
            bit lit;
            p = it.pixel_index;
            j = it.frame_step;
            q = it.chase_phase;
            if (p >= STRIP_PIXELS_DEF) return '0;
            // a phase of three never matches p % 3
            lit = (p % 3) == q;
            case (mode)
                MODE_RAINBOW:       return ramp((p + j) & 255);
                MODE_RAINBOW_CYCLE: return ramp((p * 256 / STRIP_PIXELS_DEF + j) & 255);
                MODE_CHASE:         return lit ? chase : '0;
                default:            return lit ? ramp((p - q + j) % 255) : '0;
            endcase
        endfunction

        function void note_pixel(t_in_item it);
            logic [COLOR_W-1:0] c;
            t_out_item          e;
            c = shade(it);
            for (int k = 0; k < BITS_PER_PIXEL; k++) begin
                e.pwm_code    = c[BITS_PER_PIXEL - 1 - k] ? one : zero;
                e.pixel_color = c;
                e.bit_last    = (k == BITS_PER_PIXEL - 1);
                code_q.push_back(e);
            end
        endfunction

        function void check_code(t_out_item got);
            t_out_item want;
            if (code_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected code %h color %h last %b", $realtime,
                             got.pwm_code, got.pixel_color, got.bit_last);
                return;
            end
            want = code_q.pop_front();
            if (got.pwm_code !== want.pwm_code || got.pixel_color !== want.pixel_color ||
                got.bit_last !== want.bit_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: code %h/%h color %h/%h last %b/%b (expected/actual)",
                             $realtime, want.pwm_code, got.pwm_code, want.pixel_color,
                             got.pixel_color, want.bit_last, got.bit_last);
            end
        endfunction

        function int pending();
            return code_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    t_in_item              pix_item = '0;
    logic                  code_valid;
    logic                  code_stall = 1'b0;
    t_out_item             code_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;

    pixel_scoreboard sb = new();

    led_strip_effect_pixel_encoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (pix_valid),
        .o_in_stall  (pix_stall),
        .i_in_item   (pix_item),
        .o_out_valid (code_valid),
        .i_out_stall (code_stall),
        .o_out_item  (code_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_pixel(logic [PIXEL_W-1:0] p, logic [STEP_W-1:0] j,
                              logic [PHASE_W-1:0] q);
        t_in_item it;
        int       gap;
        it.pixel_index = p;
        it.frame_step  = j;
        it.chase_phase = q;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item  <= it;
        do @(posedge clk); while (pix_stall);
        sb.note_pixel(it);
    endtask

    task automatic send_random_pixel();
        logic [PIXEL_W-1:0] p;
        logic [PHASE_W-1:0] q;
        p = $urandom_range(0, 63);
        // at least half the items hit the lit phase so the chase modes show color
        q = $urandom_range(0, 1) ? PHASE_W'(p % 3) : PHASE_W'($urandom_range(0, 3));
        send_pixel(p, STEP_W'($urandom_range(0, 2047)), q);
    endtask

    task automatic load_setup(logic [1:0] mode, logic [COLOR_W-1:0] color,
                              logic [CODE_W-1:0] one, logic [CODE_W-1:0] zero);
        logic [CFG_IDX_W-1:0]  regs [4] = '{CFG_EFFECT_MODE, CFG_CHASE_COLOR,
                                            CFG_ONE_CODE, CFG_ZERO_CODE};
        logic [CFG_DATA_W-1:0] vals [4];
        // unused upper data bits carry noise
        vals[0] = CFG_DATA_W'($urandom() << 2) | CFG_DATA_W'(mode);
        vals[1] = color;
        vals[2] = CFG_DATA_W'($urandom() << 16) | CFG_DATA_W'(one);
        vals[3] = CFG_DATA_W'($urandom() << 16) | CFG_DATA_W'(zero);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // result side: random stall after every code while idle_on is set, one long hold on request
    initial begin : code_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (code_valid === 1'b1 && !code_stall) begin
                sb.check_code(code_item);
                hold_left = idle_on ? $urandom_range(0, 15) : 0;
            end
            if (long_hold_req) begin
                hold_left     = 400;
                long_hold_req = 1'b0;
            end
            code_stall <= (hold_left > 0);
            if (hold_left > 0) hold_left--;
        end
    end

    initial begin : stimulus
        logic [COLOR_W-1:0] color;
        logic [CODE_W-1:0]  one;
        logic [CODE_W-1:0]  zero;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset values
        send_pixel(6'd0, 11'd0, 2'd0);
        send_pixel(6'd63, 11'd2047, 2'd3);
        drain();

        // rainbow across the wheel segment edges
        load_setup(MODE_RAINBOW, 24'h5AA5C3, 16'hFFFF, 16'h0000);
        send_pixel(6'd0, 11'd0, 2'd0);
        send_pixel(6'd0, 11'd84, 2'd1);
        send_pixel(6'd1, 11'd84, 2'd2);
        send_pixel(6'd0, 11'd86, 2'd0);
        send_pixel(6'd0, 11'd169, 2'd0);
        send_pixel(6'd0, 11'd170, 2'd0);
        send_pixel(6'd1, 11'd170, 2'd0);
        send_pixel(6'd63, 11'd192, 2'd3);
        send_pixel(6'd63, 11'd2047, 2'd3);
        drain();

        load_setup(MODE_RAINBOW_CYCLE, 24'h000000, 16'h0000, 16'hFFFF);
        send_pixel(6'd63, 11'd2047, 2'd0);
        send_pixel(6'd32, 11'd0, 2'd1);
        send_pixel(6'd0, 11'd1279, 2'd2);
        drain();

        load_setup(MODE_CHASE, 24'hFFFFFF, 16'h1234, 16'hABCD);
        send_pixel(6'd0, 11'd0, 2'd0);
        send_pixel(6'd1, 11'd5, 2'd0);
        send_pixel(6'd63, 11'd2047, 2'd0);
        send_pixel(6'd5, 11'd17, 2'd2);
        send_pixel(6'd3, 11'd9, 2'd3);
        drain();

        // chase rainbow with the modulo 255 wrap of large steps
        load_setup(MODE_CHASE_RAINBOW, 24'h00FF00, 16'h8001, 16'h7FFE);
        send_pixel(6'd2, 11'd2047, 2'd2);
        send_pixel(6'd0, 11'd254, 2'd0);
        send_pixel(6'd0, 11'd255, 2'd0);
        send_pixel(6'd3, 11'd0, 2'd0);
        send_pixel(6'd62, 11'd1279, 2'd2);
        send_pixel(6'd7, 11'd100, 2'd3);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph % 3) != 2;
            color = (ph == 2) ? 24'h000000 : (ph == 6) ? 24'hFFFFFF : COLOR_W'($urandom());
            one   = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : CODE_W'($urandom());
            zero  = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : CODE_W'($urandom());
            load_setup(ph[1:0], color, one, zero);
            // back pressure: sink holds off while pixels keep coming
            if (ph == 5) begin
                idle_on       = 1'b0;
                long_hold_req = 1'b1;
            end
            repeat (31) send_random_pixel();
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("led_strip_effect_pixel_encoder_core test passed");
        end else begin
            $display("led_strip_effect_pixel_encoder_core test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("led_strip_effect_pixel_encoder_core test failed");
        $finish;
    end

endmodule

[files.f]
src/lsep_pkg.sv
src/lsep_color.sv
src/led_strip_effect_pixel_encoder_core.sv
src/lsep_checker.sv
tb/sv/led_strip_effect_pixel_encoder_core_test.sv
